// ===== hw/rtl/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

   localparam int CSR_WIDTH = 7;

   typedef struct packed {
      logic step;
      logic shift;
      logic clear;
   } ctl_type;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// One cell of the compacted monotonic candidate queue.
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int AGE_WIDTH    = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swm_pkg::ctl_type         ctl,
   input  logic [SAMPLE_WIDTH-1:0]  sample,
   input  logic                     up_valid,
   input  logic [SAMPLE_WIDTH-1:0]  up_value,
   input  logic [AGE_WIDTH-1:0]     up_age,
   input  logic                     keep_prev,
   output logic                     keep,
   output logic                     valid,
   output logic [SAMPLE_WIDTH-1:0]  value,
   output logic [AGE_WIDTH-1:0]     age
);
   import swm_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   logic [SAMPLE_WIDTH-1:0] value_ff;
   logic [SAMPLE_WIDTH-1:0] value_in;
   logic [AGE_WIDTH-1:0]    age_ff;
   logic [AGE_WIDTH-1:0]    age_in;
   logic                    src_valid;
   logic [SAMPLE_WIDTH-1:0] src_value;
   logic [AGE_WIDTH-1:0]    src_age;
   logic                    insert;

   assign src_valid = ctl.shift ? up_valid : valid_ff;
   assign src_value = ctl.shift ? up_value : value_ff;
   assign src_age   = ctl.shift ? up_age   : age_ff;

   assign keep   = src_valid && ($signed(src_value) > $signed(sample));
   assign insert = !keep && keep_prev;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.step) begin
         valid_in = keep || insert;
         value_in = keep ? src_value : sample;
         age_in   = keep ? src_age + 1'b1 : '0;
      end else if (ctl.shift) begin
         valid_in = src_valid;
         value_in = src_value;
         age_in   = src_age;
      end
      if (ctl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule

// ===== hw/rtl/sliding_window_maximum.sv =====
// Top level of the sliding window maximum block.
//
// Samples arrive on the req_ channel: req_tdata carries the signed sample and
// req_tlast marks the final sample of a sequence. Once a sequence has seen at
// least window_size samples, each accepted item yields one result item on the
// rsp_ channel carrying the maximum of the last window_size samples.
// A sequence shorter than the window yields nothing, and all sequence state
// clears after the item that carries req_tlast.
// The window size is written through csr_wr_en and csr_wr_data; the user must
// write it only while the block is idle; the block does not enforce this. Zero
// acts as one and values above WINDOW_MAX act as WINDOW_MAX. A row of
// WINDOW_MAX cells holds the candidate queue with its head in the first cell,
// so the result of an item is shown in the cycle after it is accepted. One
// item per cycle is sustained while results are taken; once the window
// shrinks, each stale candidate beyond the first goes before the next item.
// Reset empties the queue and sets the window size to one.
// While a result waits on a stalled receiver, req_tready stays low and the
// result is held unchanged until it is taken.
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32,
   parameter int DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [DATA_WIDTH-1:0]           req_tdata,   // sample
   input  logic                            req_tlast,   // last_sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [DATA_WIDTH-1:0]           rsp_tdata,   // window_max
   input  logic                            csr_wr_en,
   input  logic [swm_pkg::CSR_WIDTH-1:0]   csr_wr_data
);
   import swm_pkg::*;

   localparam int WIN_WIDTH = $clog2(WINDOW_MAX + 1);
   localparam int CMP_WIDTH = (WIN_WIDTH > CSR_WIDTH) ? WIN_WIDTH : CSR_WIDTH;

   logic [CSR_WIDTH-1:0]    window_size_ff;
   logic [CMP_WIDTH-1:0]    wsz_ext;
   logic [WIN_WIDTH-1:0]    win;
   logic [WIN_WIDTH-1:0]    seen_ff;
   logic [WIN_WIDTH-1:0]    seen_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_data_in;

   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    accept;
   logic                    evict;
   logic                    drain;
   logic                    emit;
   logic [SAMPLE_WIDTH-1:0] head_value;
   logic [SAMPLE_WIDTH-1:0] result;
   ctl_type                 ctl;

   logic                    cell_valid [WINDOW_MAX];
   logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic [WIN_WIDTH-1:0]    cell_age   [WINDOW_MAX];
   logic                    cell_keep  [WINDOW_MAX];

   assign sample = req_tdata[SAMPLE_WIDTH-1:0];

   assign wsz_ext = CMP_WIDTH'(window_size_ff);
   always_comb begin
      if (wsz_ext == '0) begin
         win = WIN_WIDTH'(1);
      end else if (wsz_ext > CMP_WIDTH'(WINDOW_MAX)) begin
         win = WIN_WIDTH'(WINDOW_MAX);
      end else begin
         win = WIN_WIDTH'(wsz_ext);
      end
   end

   assign evict = cell_valid[0] && ((cell_age[0] + 1'b1) >= win);
   assign drain = cell_valid[1] && ((cell_age[1] + 1'b1) >= win);

   assign req_tready = (!rsp_valid_ff || rsp_tready) && !drain;
   assign accept     = req_tvalid && req_tready;

   assign ctl.step  = accept;
   assign ctl.shift = (accept && evict) || drain;
   assign ctl.clear = accept && req_tlast;

   assign head_value = evict ? cell_value[1] : cell_value[0];
   assign result     = cell_keep[0] ? head_value : sample;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (seen_ff < win) begin
            seen_in = seen_ff + 1'b1;
         end
         if (req_tlast) begin
            seen_in = '0;
         end
      end
   end

   assign emit = (seen_ff < win) ? ((seen_ff + 1'b1) >= win) : 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CSR_WIDTH'(1);
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_size_ff <= csr_wr_data;
         end
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_WIDTH'(rsp_data_ff);

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic                    up_valid;
      logic [SAMPLE_WIDTH-1:0] up_value;
      logic [WIN_WIDTH-1:0]    up_age;
      logic                    keep_prev;

      if (i + 1 < WINDOW_MAX) begin : g_up
         assign up_valid = cell_valid[i+1];
         assign up_value = cell_value[i+1];
         assign up_age   = cell_age[i+1];
      end else begin : g_end
         assign up_valid = 1'b0;
         assign up_value = '0;
         assign up_age   = '0;
      end

      if (i == 0) begin : g_head
         assign keep_prev = 1'b1;
      end else begin : g_body
         assign keep_prev = cell_keep[i-1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_WIDTH    (WIN_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sample    (sample),
         .up_valid  (up_valid),
         .up_value  (up_value),
         .up_age    (up_age),
         .keep_prev (keep_prev),
         .keep      (cell_keep[i]),
         .valid     (cell_valid[i]),
         .value     (cell_value[i]),
         .age       (cell_age[i])
      );
   end

endmodule

// ===== hw/rtl/swm_checker.sv =====
// Port-level checks of the sliding window maximum block and their binding.
module swm_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [DATA_WIDTH-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result item changed or vanished.");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input item taken while a result item is stalled.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result item shown right after reset.");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("Result item appeared without an accepted input item.");

endmodule

bind sliding_window_maximum swm_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
